// ===== sv/rtmhd_pkg.sv =====
// Shared types, constants and microcode table for the ray/triangle farthest-hit core.
`default_nettype none
package rtmhd_pkg;

    localparam int TRI_DEPTH_DEF = 1024;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TRI_WORDS     = 9;
    localparam int DET_W         = 102;
    localparam int CX_W          = 67;
    localparam int SING_DEN      = 100000000;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] VEC_E1  = 2'd0;
    localparam logic [1:0] VEC_E2  = 2'd1;
    localparam logic [1:0] VEC_B   = 2'd2;
    localparam logic [1:0] VEC_DIR = 2'd3;

    localparam logic [6:0] DOT_BASE  = 7'd36;
    localparam logic [6:0] STEP_NORM = 7'd68;
    localparam logic [6:0] STEP_PREP = 7'd69;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_CAP,
        UOP_QINIT,
        UOP_LDV,
        UOP_EDGE,
        UOP_TERM,
        UOP_WCX,
        UOP_WDET,
        UOP_NORM,
        UOP_PREP,
        UOP_DIVINIT,
        UOP_DIVSTEP,
        UOP_UPD
    } t_uop_kind;

    typedef struct packed {
        t_uop_kind  kind;
        logic [1:0] va;
        logic [1:0] ca;
        logic       bcx;
        logic [1:0] vb;
        logic [1:0] cb;
        logic [3:0] xi;
        logic       hi;
        logic       neg;
        logic       first;
        logic [3:0] dst;
    } t_uop;

    typedef struct packed {
        logic accept;
        logic sat;
    } t_status;

    // Cross products first (e2 x dir, b x dir, e2 x b), then the four dot products,
    // then sign normalization and the hit-test preparation.
    function automatic t_uop uop_at(input logic [6:0] step);
        t_uop       u;
        logic [3:0] g;
        logic [1:0] k;
        logic [1:0] k1;
        logic [1:0] k2;
        logic [1:0] va;
        logic [1:0] vb;
        logic [1:0] c;
        logic [6:0] s2;
        logic [2:0] ph8;
        logic [3:0] base;
        u    = '0;
        g    = step[5:2];
        s2   = step - DOT_BASE;
        ph8  = s2[2:0];
        k    = 2'd0;
        va   = VEC_E1;
        vb   = VEC_E1;
        base = 4'd0;
        c    = ph8[2:1];
        if (step == STEP_NORM) begin
            u.kind = UOP_NORM;
        end else if (step == STEP_PREP) begin
            u.kind = UOP_PREP;
        end else if (step < DOT_BASE) begin
            case (g)
                4'd0, 4'd1, 4'd2: begin
                    va = VEC_E2;
                    vb = VEC_DIR;
                end
                4'd3, 4'd4, 4'd5: begin
                    va = VEC_B;
                    vb = VEC_DIR;
                end
                default: begin
                    va = VEC_E2;
                    vb = VEC_B;
                end
            endcase
            case (g)
                4'd0, 4'd3, 4'd6: k = 2'd0;
                4'd1, 4'd4, 4'd7: k = 2'd1;
                default:          k = 2'd2;
            endcase
            k1 = (k == 2'd2) ? 2'd0 : k + 2'd1;
            k2 = (k == 2'd0) ? 2'd2 : k - 2'd1;
            case (step[1:0])
                2'd0: begin
                    u.kind  = UOP_TERM;
                    u.va    = va;
                    u.ca    = k1;
                    u.vb    = vb;
                    u.cb    = k2;
                    u.first = 1'b1;
                end
                2'd1: begin
                    u.kind = UOP_TERM;
                    u.va   = va;
                    u.ca   = k2;
                    u.vb   = vb;
                    u.cb   = k1;
                    u.neg  = 1'b1;
                end
                2'd2: u.kind = UOP_NOP;
                default: begin
                    u.kind = UOP_WCX;
                    u.dst  = g;
                end
            endcase
        end else begin
            va = (s2[4:3] == 2'd1) ? VEC_B : VEC_E1;
            case (s2[4:3])
                2'd2:    base = 4'd3;
                2'd3:    base = 4'd6;
                default: base = 4'd0;
            endcase
            if (ph8 < 3'd6) begin
                u.kind  = UOP_TERM;
                u.va    = va;
                u.ca    = c;
                u.bcx   = 1'b1;
                u.xi    = base + {2'b00, c};
                u.hi    = ph8[0];
                u.first = (ph8 == 3'd0);
            end else if (ph8 == 3'd6) begin
                u.kind = UOP_NOP;
            end else begin
                u.kind = UOP_WDET;
                u.dst  = {2'b00, s2[4:3]};
            end
        end
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== sv/ray_triangle_max_hit_distance_core.sv =====
// Top level of the ray/triangle farthest-hit core: controller, datapath and triangle store.
`default_nettype none
// A store word (command 0) writes the nine words of one triangle into the store after it is
// taken and produces no result; a slot at or beyond the store depth is dropped. A query word
// (command 1) tests the first triangle_count stored triangles against the ray from p0 along
// -p1 and pulses o_valid for one cycle with the largest hit distance. Each triangle takes nine
// store reads, an edge step and 70 microcode steps on the shared 33x34 multiplier, then the
// decision; a saturated hit adds an update step, and any other hit first runs a 32-step
// restoring divider that produces the distance. The result cannot be stalled: the receiver
// must take it in the cycle it is shown. busy stays high from the cycle after a query word
// or an in-range store word is taken until the write ends or the result is shown.
module ray_triangle_max_hit_distance_core #(
    parameter int TRI_DEPTH = rtmhd_pkg::TRI_DEPTH_DEF,
    parameter int FRAC_BITS = rtmhd_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [9:0]         i_slot,
    input  logic signed [31:0] i_p0_x,
    input  logic signed [31:0] i_p0_y,
    input  logic signed [31:0] i_p0_z,
    input  logic signed [31:0] i_p1_x,
    input  logic signed [31:0] i_p1_y,
    input  logic signed [31:0] i_p1_z,
    input  logic signed [31:0] i_p2_x,
    input  logic signed [31:0] i_p2_y,
    input  logic signed [31:0] i_p2_z,
    input  logic               i_cfg_we,
    input  logic [10:0]        i_cfg_wdata,
    output logic               o_valid,
    output logic [31:0]        o_max_distance,
    output logic               o_any_hit
);
    import rtmhd_pkg::*;

    localparam int AW = $clog2(TRI_WORDS * TRI_DEPTH);

    t_uop          cmd;
    t_status       status;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [31:0]   wdata;
    logic [31:0]   rdata;

    rtmhd_ctrl #(
        .TRI_DEPTH(TRI_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_command  (i_command),
        .i_slot     (i_slot),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_mem_we   (mem_we),
        .o_mem_re   (mem_re),
        .o_mem_addr (mem_addr),
        .o_busy     (busy),
        .o_valid    (o_valid)
    );

    rtmhd_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_p0_x        (i_p0_x),
        .i_p0_y        (i_p0_y),
        .i_p0_z        (i_p0_z),
        .i_p1_x        (i_p1_x),
        .i_p1_y        (i_p1_y),
        .i_p1_z        (i_p1_z),
        .i_p2_x        (i_p2_x),
        .i_p2_y        (i_p2_y),
        .i_p2_z        (i_p2_z),
        .i_rdata       (rdata),
        .o_wdata       (wdata),
        .o_status      (status),
        .o_max_distance(o_max_distance),
        .o_any_hit     (o_any_hit)
    );

    rtmhd_store #(
        .TRI_DEPTH(TRI_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_re   (mem_re),
        .i_addr (mem_addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_QUERY) |=> (busy && !o_valid))
        else $error("query word taken without going busy");

    a_hit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_max_distance != 32'd0) |-> o_any_hit)
        else $error("nonzero distance without a hit");

endmodule
`default_nettype wire

// ===== sv/rtmhd_store.sv =====
// Triangle store: nine coordinate words per triangle, one write or read per cycle.
`default_nettype none
module rtmhd_store #(
    parameter int TRI_DEPTH = rtmhd_pkg::TRI_DEPTH_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_we,
    input  logic                                            i_re,
    input  logic [$clog2(rtmhd_pkg::TRI_WORDS*TRI_DEPTH)-1:0] i_addr,
    input  logic [31:0]                                     i_wdata,
    output logic [31:0]                                     o_rdata
);
    import rtmhd_pkg::*;

    localparam int DEPTH = TRI_WORDS * TRI_DEPTH;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/rtmhd_datapath.sv =====
// Datapath: operand registers, shared multiplier, determinant accumulator and divider.
`default_nettype none
module rtmhd_datapath #(
    parameter int FRAC_BITS = rtmhd_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rtmhd_pkg::t_uop      i_cmd,
    input  logic signed [31:0]   i_p0_x,
    input  logic signed [31:0]   i_p0_y,
    input  logic signed [31:0]   i_p0_z,
    input  logic signed [31:0]   i_p1_x,
    input  logic signed [31:0]   i_p1_y,
    input  logic signed [31:0]   i_p1_z,
    input  logic signed [31:0]   i_p2_x,
    input  logic signed [31:0]   i_p2_y,
    input  logic signed [31:0]   i_p2_z,
    input  logic [31:0]          i_rdata,
    output logic [31:0]          o_wdata,
    output rtmhd_pkg::t_status   o_status,
    output logic [31:0]          o_max_distance,
    output logic                 o_any_hit
);
    import rtmhd_pkg::*;

    localparam int SUM_W = DET_W + 1;
    localparam int MUL_W = DET_W + 10;
    localparam int SAT_W = DET_W + 32;
    localparam logic [DET_W-1:0] POW = DET_W'(1) << (3 * FRAC_BITS);
    localparam logic [DET_W-1:0] THR_U = (POW + DET_W'(SING_DEN - 1)) / DET_W'(SING_DEN);
    localparam logic signed [DET_W-1:0] THR = THR_U;

    logic [31:0]              r_in  [TRI_WORDS];
    logic [31:0]              r_tri [TRI_WORDS];
    logic signed [32:0]       r_e1  [3];
    logic signed [32:0]       r_e2  [3];
    logic signed [32:0]       r_b   [3];
    logic signed [32:0]       r_dir [3];
    logic signed [CX_W-1:0]   r_cx  [9];
    logic signed [DET_W-1:0]  r_det [4];
    logic signed [DET_W-1:0]  r_acc;
    logic signed [CX_W-1:0]   r_prod;
    logic                     r_pv;
    logic                     r_pfirst;
    logic                     r_phi;
    logic                     r_pneg;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [MUL_W-1:0]  r_dt1000;
    logic                     r_sat;
    logic                     r_magok;
    logic                     r_uvok;
    logic [DET_W-1:0]         r_rem;
    logic [31:0]              r_nlo;
    logic [31:0]              r_quo;
    logic [31:0]              r_best;
    logic                     r_hit;

    logic signed [32:0]       op_a;
    logic signed [32:0]       vb_val;
    logic signed [33:0]       op_b;
    logic signed [DET_W-1:0]  t_ext;
    logic signed [DET_W-1:0]  t_sh;
    logic signed [DET_W-1:0]  t_fin;
    logic [DET_W:0]           trial;
    logic [DET_W:0]           dext;
    logic [31:0]              q_val;

    function automatic logic signed [32:0] sx(input logic [31:0] v);
        return {v[31], v};
    endfunction

    always_comb begin
        case (i_cmd.va)
            VEC_E1:  op_a = r_e1[i_cmd.ca];
            VEC_E2:  op_a = r_e2[i_cmd.ca];
            VEC_B:   op_a = r_b[i_cmd.ca];
            default: op_a = r_dir[i_cmd.ca];
        endcase
        case (i_cmd.vb)
            VEC_E1:  vb_val = r_e1[i_cmd.cb];
            VEC_E2:  vb_val = r_e2[i_cmd.cb];
            VEC_B:   vb_val = r_b[i_cmd.cb];
            default: vb_val = r_dir[i_cmd.cb];
        endcase
        if (i_cmd.bcx) begin
            if (i_cmd.hi) begin
                op_b = r_cx[i_cmd.xi][CX_W-1:33];
            end else begin
                op_b = {1'b0, r_cx[i_cmd.xi][32:0]};
            end
        end else begin
            op_b = {vb_val[32], vb_val};
        end
    end

    always_comb begin
        t_ext = DET_W'(r_prod);
        t_sh  = r_phi ? (t_ext <<< 33) : t_ext;
        t_fin = r_pneg ? -t_sh : t_sh;
        trial = {r_rem, r_nlo[31]};
        dext  = SUM_W'($unsigned(r_det[0]));
        q_val = r_sat ? '1 : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= (i_cmd.kind == UOP_TERM);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= op_a * op_b;
        r_pfirst <= i_cmd.first;
        r_phi    <= i_cmd.hi;
        r_pneg   <= i_cmd.neg;
        if (r_pv) begin
            r_acc <= r_pfirst ? t_fin : r_acc + t_fin;
        end
        case (i_cmd.kind)
            UOP_CAP: begin
                r_in[0] <= i_p0_x;
                r_in[1] <= i_p0_y;
                r_in[2] <= i_p0_z;
                r_in[3] <= i_p1_x;
                r_in[4] <= i_p1_y;
                r_in[5] <= i_p1_z;
                r_in[6] <= i_p2_x;
                r_in[7] <= i_p2_y;
                r_in[8] <= i_p2_z;
            end
            UOP_QINIT: begin
                for (int k = 0; k < 3; k++) begin
                    r_dir[k] <= -sx(r_in[3 + k]);
                end
                r_best <= '0;
                r_hit  <= 1'b0;
            end
            UOP_LDV: begin
                r_tri[i_cmd.dst] <= i_rdata;
            end
            UOP_EDGE: begin
                for (int k = 0; k < 3; k++) begin
                    r_e1[k] <= sx(r_tri[k]) - sx(r_tri[3 + k]);
                    r_e2[k] <= sx(r_tri[k]) - sx(r_tri[6 + k]);
                    r_b[k]  <= sx(r_tri[k]) - sx(r_in[k]);
                end
            end
            UOP_WCX: begin
                r_cx[i_cmd.dst] <= r_acc[CX_W-1:0];
            end
            UOP_WDET: begin
                r_det[i_cmd.dst[1:0]] <= r_acc;
            end
            UOP_NORM: begin
                for (int j = 0; j < 4; j++) begin
                    r_det[j] <= r_det[0][DET_W-1] ? -r_det[j] : r_det[j];
                end
            end
            UOP_PREP: begin
                r_sum    <= SUM_W'(r_det[1]) + SUM_W'(r_det[2]);
                r_dt1000 <= (MUL_W'(r_det[3]) <<< 10) - (MUL_W'(r_det[3]) <<< 4)
                            - (MUL_W'(r_det[3]) <<< 3);
                r_sat    <= SAT_W'(r_det[3]) >= (SAT_W'(r_det[0]) <<< (32 - FRAC_BITS));
                r_magok  <= r_det[0] >= THR;
                r_uvok   <= !r_det[1][DET_W-1] && !r_det[2][DET_W-1];
            end
            UOP_DIVINIT: begin
                r_rem <= $unsigned(r_det[3]) >> (32 - FRAC_BITS);
                r_nlo <= r_det[3][31:0] << FRAC_BITS;
                r_quo <= '0;
            end
            UOP_DIVSTEP: begin
                if (trial >= dext) begin
                    r_rem <= DET_W'(trial - dext);
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= DET_W'(trial);
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_nlo <= {r_nlo[30:0], 1'b0};
            end
            UOP_UPD: begin
                if (q_val > r_best) begin
                    r_best <= q_val;
                end
                r_hit <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_wdata         = r_in[i_cmd.dst];
    assign o_status.accept = r_magok && r_uvok && (r_sum <= SUM_W'(r_det[0]))
                             && (r_dt1000 >= MUL_W'(r_det[0]));
    assign o_status.sat    = r_sat;
    assign o_max_distance  = r_best;
    assign o_any_hit       = r_hit;

endmodule
`default_nettype wire

// ===== sv/rtmhd_ctrl.sv =====
// Controller: sequences store writes, triangle loads, microcode, division and result.
`default_nettype none
module rtmhd_ctrl #(
    parameter int TRI_DEPTH = rtmhd_pkg::TRI_DEPTH_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_start,
    input  logic                                              i_command,
    input  logic [9:0]                                        i_slot,
    input  logic                                              i_cfg_we,
    input  logic [10:0]                                       i_cfg_wdata,
    input  rtmhd_pkg::t_status                                i_status,
    output rtmhd_pkg::t_uop                                   o_cmd,
    output logic                                              o_mem_we,
    output logic                                              o_mem_re,
    output logic [$clog2(rtmhd_pkg::TRI_WORDS*TRI_DEPTH)-1:0] o_mem_addr,
    output logic                                              o_busy,
    output logic                                              o_valid
);
    import rtmhd_pkg::*;

    localparam int AW = $clog2(TRI_WORDS * TRI_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_QINIT,
        S_LOAD,
        S_EDGE,
        S_CALC,
        S_DECIDE,
        S_DIV,
        S_UPDATE,
        S_NEXT,
        S_DONE
    } t_state;

    t_state      r_state;
    logic [10:0] r_count;
    logic [10:0] r_lim;
    logic [10:0] r_idx;
    logic [3:0]  r_k;
    logic [6:0]  r_step;
    logic [4:0]  r_div;
    logic        r_busy;
    logic        r_valid;
    logic [10:0] lim_c;

    assign lim_c = (int'(r_count) > TRI_DEPTH) ? 11'(TRI_DEPTH) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_lim   <= '0;
            r_idx   <= '0;
            r_k     <= '0;
            r_step  <= '0;
            r_div   <= '0;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_k <= '0;
                        if (i_command == CMD_QUERY) begin
                            r_state <= S_QINIT;
                            r_busy  <= 1'b1;
                        end else if (int'(i_slot) < TRI_DEPTH) begin
                            r_idx   <= {1'b0, i_slot};
                            r_state <= S_WRITE;
                            r_busy  <= 1'b1;
                        end
                    end
                end
                S_WRITE: begin
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'(TRI_WORDS - 1)) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_QINIT: begin
                    r_lim <= lim_c;
                    r_idx <= '0;
                    r_k   <= '0;
                    r_state <= (lim_c == '0) ? S_DONE : S_LOAD;
                end
                S_LOAD: begin
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'(TRI_WORDS)) begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    r_step  <= '0;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_step <= r_step + 7'd1;
                    if (r_step == STEP_PREP) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_div <= '0;
                    if (!i_status.accept) begin
                        r_state <= S_NEXT;
                    end else if (i_status.sat) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div <= r_div + 5'd1;
                    if (r_div == '1) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_k <= '0;
                    if (r_idx + 11'd1 == r_lim) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 11'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_mem_we   = 1'b0;
        o_mem_re   = 1'b0;
        o_mem_addr = AW'(int'(r_idx) * TRI_WORDS + int'(r_k));
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.kind = UOP_CAP;
                end
            end
            S_WRITE: begin
                o_mem_we  = 1'b1;
                o_cmd.dst = r_k;
            end
            S_QINIT:  o_cmd.kind = UOP_QINIT;
            S_LOAD: begin
                o_mem_re = (r_k < 4'(TRI_WORDS));
                if (r_k != 4'd0) begin
                    o_cmd.kind = UOP_LDV;
                    o_cmd.dst  = r_k - 4'd1;
                end
            end
            S_EDGE:   o_cmd.kind = UOP_EDGE;
            S_CALC:   o_cmd = uop_at(r_step);
            S_DECIDE: o_cmd.kind = UOP_DIVINIT;
            S_DIV:    o_cmd.kind = UOP_DIVSTEP;
            S_UPDATE: o_cmd.kind = UOP_UPD;
            default: begin
            end
        endcase
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

endmodule
`default_nettype wire
